// ===== design/rwcgs_pkg.sv =====
package rwcgs_pkg;

  localparam int GROUP_BITS = 6;
  localparam int COUNT_BITS = 7;
  localparam int ID_BITS = 32;
  localparam logic [GROUP_BITS-1:0] GROUP_TOP = 6'd63;
  localparam logic [COUNT_BITS-1:0] MAX_PER_GROUP_RESET = 7'd8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_REL   = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [ID_BITS-1:0] rel_id;
    logic               rel_is_write;
    logic               barrier;
    logic               upsert;
  } req_t;

  typedef struct packed {
    logic [GROUP_BITS-1:0] group;
    logic [COUNT_BITS-1:0] group_count;
    logic                  overflow;
  } rsp_t;

endpackage

// ===== design/read_write_conflict_group_scheduler.sv =====
// Assigns each entry of a request batch to an execution group. A relation word scans
// the stored relation records one per cycle through the record memory read port, then
// drains the compare pipeline, stores the record and returns to idle. A close word scans
// the closed entries one per cycle through the entry memory read port, and it finishes
// only once the output register is free. One word is worked on at a time; a new word is
// taken while a finished result still waits on the output.
module read_write_conflict_group_scheduler #(
  parameter int MAX_ENTRIES   = 64,
  parameter int MAX_RECORDS   = 128,
  parameter int TABLE_ID_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [rwcgs_pkg::COUNT_BITS-1:0]     cfg_wr_data,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  rwcgs_pkg::req_t                      req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output rwcgs_pkg::rsp_t                      rsp
);

  localparam int RAW = $clog2(MAX_RECORDS);
  localparam int RCW = $clog2(MAX_RECORDS + 1);
  localparam int EAW = $clog2(MAX_ENTRIES);
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int SCW = (RCW > ECW) ? RCW : ECW;
  localparam int GB  = rwcgs_pkg::GROUP_BITS;
  localparam int CB  = rwcgs_pkg::COUNT_BITS;

  // record memory
  logic [TABLE_ID_BITS-1:0] rec_tab_mem [MAX_RECORDS];
  logic                     rec_wr_mem  [MAX_RECORDS];
  logic [EAW-1:0]           rec_own_mem [MAX_RECORDS];
  // entry memory
  logic [GB-1:0]            ent_grp_mem [MAX_ENTRIES];
  logic                     ent_bar_mem [MAX_ENTRIES];

  rwcgs_pkg::state_t state, state_next;
  rwcgs_pkg::op_t    op_q;

  logic [TABLE_ID_BITS-1:0] tab_q, req_tab, rec_tab_q;
  logic                     wr_q, bar_q, rec_wr_q, ent_bar_q;
  logic [EAW-1:0]           rec_own_q, ent_addr;
  logic [GB-1:0]            ent_grp_q;
  logic [SCW-1:0]           idx, scan_end;
  logic                     rec_v, ent_v;

  logic [RCW-1:0]  record_count;
  logic [ECW-1:0]  entry_count;
  logic [GB-1:0]   active_group;
  logic [CB-1:0]   group_fill;
  logic [CB-1:0]   needed_group;
  logic            overflow_seen;
  logic [CB-1:0]   max_per_group;

  logic            accept, entry_full, rec_rd, ent_rd, hit, raise, commit_go, rsp_free;
  logic [CB-1:0]   raise_val, limit, grp_w, fill_w, fill_fin;
  logic            grp_sat;
  logic [GB-1:0]   grp_fin;

  assign req_ready  = (state == rwcgs_pkg::ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign req_tab    = TABLE_ID_BITS'(req.rel_id);
  assign entry_full = (entry_count == ECW'(MAX_ENTRIES));
  assign rsp_free   = !rsp_valid || rsp_ready;

  assign rec_rd   = (state == rwcgs_pkg::ST_SCAN) && (op_q == rwcgs_pkg::OP_REL);
  assign hit      = rec_v && (rec_tab_q == tab_q) && (wr_q || rec_wr_q)
                    && (ECW'(rec_own_q) < entry_count);
  assign ent_rd   = ((state == rwcgs_pkg::ST_SCAN) && (op_q == rwcgs_pkg::OP_CLOSE)) || hit;
  assign ent_addr = (op_q == rwcgs_pkg::OP_REL) ? rec_own_q : idx[EAW-1:0];

  // shared raise compare
  assign raise_val = {1'b0, ent_grp_q} + CB'(1);
  assign raise     = ent_v && ((op_q == rwcgs_pkg::OP_REL) || bar_q || ent_bar_q)
                     && (raise_val > needed_group);

  assign commit_go = (state == rwcgs_pkg::ST_COMMIT) && ((op_q == rwcgs_pkg::OP_REL) || rsp_free);

  // group placement of a closing entry
  always_comb begin
    limit  = (max_per_group == '0) ? CB'(1) : max_per_group;
    grp_w  = {1'b0, active_group};
    fill_w = group_fill;
    if (entry_count == '0) begin
      grp_w  = '0;
      fill_w = '0;
    end else begin
      if (needed_group > grp_w) begin
        grp_w  = needed_group;
        fill_w = '0;
      end
      if (fill_w >= limit) begin
        grp_w  = grp_w + CB'(1);
        fill_w = '0;
      end
    end
    grp_sat  = (grp_w > {1'b0, rwcgs_pkg::GROUP_TOP});
    grp_fin  = grp_sat ? rwcgs_pkg::GROUP_TOP : grp_w[GB-1:0];
    fill_fin = (fill_w == {CB{1'b1}}) ? fill_w : fill_w + CB'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwcgs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rwcgs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.op)
            rwcgs_pkg::OP_REL: begin
              if (!entry_full) begin
                state_next = (record_count != '0) ? rwcgs_pkg::ST_SCAN : rwcgs_pkg::ST_COMMIT;
              end
            end
            rwcgs_pkg::OP_CLOSE: begin
              state_next = (!entry_full && entry_count != '0) ? rwcgs_pkg::ST_SCAN
                                                              : rwcgs_pkg::ST_COMMIT;
            end
            default: state_next = rwcgs_pkg::ST_IDLE;
          endcase
        end
      end
      rwcgs_pkg::ST_SCAN: begin
        if (idx == scan_end) state_next = rwcgs_pkg::ST_DRAIN;
      end
      rwcgs_pkg::ST_DRAIN: begin
        if (!rec_v && !ent_v) state_next = rwcgs_pkg::ST_COMMIT;
      end
      rwcgs_pkg::ST_COMMIT: begin
        if (commit_go) state_next = rwcgs_pkg::ST_IDLE;
      end
      default: state_next = rwcgs_pkg::ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (rec_rd) begin
      rec_tab_q <= rec_tab_mem[idx[RAW-1:0]];
      rec_wr_q  <= rec_wr_mem[idx[RAW-1:0]];
      rec_own_q <= rec_own_mem[idx[RAW-1:0]];
    end
    if (commit_go && op_q == rwcgs_pkg::OP_REL && record_count < RCW'(MAX_RECORDS)) begin
      rec_tab_mem[record_count[RAW-1:0]] <= tab_q;
      rec_wr_mem[record_count[RAW-1:0]]  <= wr_q;
      rec_own_mem[record_count[RAW-1:0]] <= entry_count[EAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rd) begin
      ent_grp_q <= ent_grp_mem[ent_addr];
      ent_bar_q <= ent_bar_mem[ent_addr];
    end
    if (commit_go && op_q == rwcgs_pkg::OP_CLOSE && !entry_full) begin
      ent_grp_mem[entry_count[EAW-1:0]] <= grp_fin;
      ent_bar_mem[entry_count[EAW-1:0]] <= bar_q;
    end
  end

  // word capture and scan counter
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.op;
      tab_q <= req_tab;
      wr_q  <= req.rel_is_write;
      bar_q <= req.barrier;
      idx   <= '0;
      if (req.op == rwcgs_pkg::OP_REL) begin
        scan_end <= SCW'(record_count - RCW'(1));
      end else begin
        scan_end <= SCW'(entry_count - ECW'(1));
      end
    end else if (state == rwcgs_pkg::ST_SCAN) begin
      idx <= idx + SCW'(1);
    end
  end

  // batch state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_v         <= 1'b0;
      ent_v         <= 1'b0;
      record_count  <= '0;
      entry_count   <= '0;
      active_group  <= '0;
      group_fill    <= '0;
      needed_group  <= '0;
      overflow_seen <= 1'b0;
      max_per_group <= rwcgs_pkg::MAX_PER_GROUP_RESET;
      rsp_valid     <= 1'b0;
    end else begin
      rec_v <= rec_rd;
      ent_v <= ent_rd;
      if (cfg_wr_en) max_per_group <= cfg_wr_data;
      if (rsp_valid && rsp_ready && !(commit_go && op_q != rwcgs_pkg::OP_REL)) begin
        rsp_valid <= 1'b0;
      end
      if (raise) needed_group <= raise_val;
      if (accept && req.op == rwcgs_pkg::OP_CLEAR) begin
        record_count  <= '0;
        entry_count   <= '0;
        active_group  <= '0;
        group_fill    <= '0;
        needed_group  <= '0;
        overflow_seen <= 1'b0;
      end
      if (accept && req.op == rwcgs_pkg::OP_REL && entry_full) overflow_seen <= 1'b1;
      if (commit_go) begin
        if (op_q == rwcgs_pkg::OP_REL) begin
          if (record_count < RCW'(MAX_RECORDS)) begin
            record_count <= record_count + RCW'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end else begin
          rsp_valid    <= 1'b1;
          needed_group <= '0;
          if (entry_full) begin
            overflow_seen   <= 1'b1;
            rsp.group       <= active_group;
            rsp.group_count <= {1'b0, active_group} + CB'(1);
            rsp.overflow    <= 1'b1;
          end else begin
            if (grp_sat) overflow_seen <= 1'b1;
            active_group    <= grp_fin;
            group_fill      <= fill_fin;
            entry_count     <= entry_count + ECW'(1);
            rsp.group       <= grp_fin;
            rsp.group_count <= {1'b0, grp_fin} + CB'(1);
            rsp.overflow    <= overflow_seen || grp_sat;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == rwcgs_pkg::ST_COMMIT)
    else $error("result raised outside commit");

  a_needed_bound: assert property (@(posedge clk) disable iff (rst)
    needed_group <= {1'b0, rwcgs_pkg::GROUP_TOP} + CB'(1))
    else $error("needed group out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= RCW'(MAX_RECORDS) && entry_count <= ECW'(MAX_ENTRIES))
    else $error("store count past capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == rwcgs_pkg::ST_SCAN |-> idx <= scan_end)
    else $error("scan index past end");

  a_group_monotonic: assert property (@(posedge clk) disable iff (rst)
    active_group < $past(active_group) |->
      $past(accept) && $past(req.op) == rwcgs_pkg::OP_CLEAR)
    else $error("current group fell without a new batch");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int ENTRY_CAP = 64;
  localparam int RECORD_CAP = 128;
  localparam int SCAN_SETTLE = RECORD_CAP + 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENT_WORDS = 165;
  localparam int PHASES = 6;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [rwcgs_pkg::COUNT_BITS-1:0] cfg_wr_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  rwcgs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rwcgs_pkg::rsp_t rsp;

  read_write_conflict_group_scheduler i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

  always #6 clk = ~clk;

  // scheduler state as seen by the predictor
  logic [rwcgs_pkg::ID_BITS-1:0] rec_table [RECORD_CAP];
  logic rec_write [RECORD_CAP];
  int unsigned rec_owner [RECORD_CAP];
  int unsigned ent_group [ENTRY_CAP];
  logic ent_barrier [ENTRY_CAP];
  int unsigned rec_n;
  int unsigned ent_n;
  int unsigned cur_group;
  int unsigned fill;
  int unsigned need;
  logic ovf;
  logic [rwcgs_pkg::COUNT_BITS-1:0] per_group;

  rwcgs_pkg::rsp_t grant_q [$];
  rwcgs_pkg::req_t pending_words [$];

  int unsigned queued_n = 0;
  int unsigned accepted_n = 0;
  int unsigned checked_n = 0;
  int unsigned batches_n = 0;
  int unsigned fail_n = 0;
  int unsigned cycle_n = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  function automatic void clear_batch();
    rec_n = 0;
    ent_n = 0;
    cur_group = 0;
    fill = 0;
    need = 0;
    ovf = 1'b0;
  endfunction

  function automatic void raise_need(int unsigned g);
    if (g + 1 > need) need = g + 1;
  endfunction

  function automatic void assign_group(rwcgs_pkg::req_t w);
    int unsigned grp;
    int unsigned cap;
    rwcgs_pkg::rsp_t grant;
    case (w.op)
      rwcgs_pkg::OP_CLEAR: clear_batch();
      rwcgs_pkg::OP_REL: begin
        if (ent_n >= ENTRY_CAP) begin
          ovf = 1'b1;
        end else begin
          for (int i = 0; i < rec_n; i++) begin
            if (rec_owner[i] < ent_n && rec_table[i] == w.rel_id &&
                (w.rel_is_write || rec_write[i]))
              raise_need(ent_group[rec_owner[i]]);
          end
          if (rec_n < RECORD_CAP) begin
            rec_table[rec_n] = w.rel_id;
            rec_write[rec_n] = w.rel_is_write;
            rec_owner[rec_n] = ent_n;
            rec_n++;
          end else begin
            ovf = 1'b1;
          end
        end
      end
      rwcgs_pkg::OP_CLOSE: begin
        if (ent_n >= ENTRY_CAP) begin
          ovf = 1'b1;
          need = 0;
          grant.group = rwcgs_pkg::GROUP_BITS'(cur_group);
          grant.group_count = rwcgs_pkg::COUNT_BITS'(cur_group + 1);
          grant.overflow = 1'b1;
        end else begin
          cap = (per_group == 0) ? 1 : per_group;
          for (int i = 0; i < ent_n; i++) begin
            if (w.barrier || ent_barrier[i]) raise_need(ent_group[i]);
          end
          if (ent_n == 0) begin
            grp = 0;
            fill = 0;
          end else begin
            grp = cur_group;
            if (need > grp) begin
              grp = need;
              fill = 0;
            end
            if (fill >= cap) begin
              grp++;
              fill = 0;
            end
          end
          if (grp > rwcgs_pkg::GROUP_TOP) begin
            grp = rwcgs_pkg::GROUP_TOP;
            ovf = 1'b1;
          end
          cur_group = grp;
          fill++;
          if (fill > 127) fill = 127;
          ent_group[ent_n] = grp;
          ent_barrier[ent_n] = w.barrier;
          ent_n++;
          need = 0;
          grant.group = rwcgs_pkg::GROUP_BITS'(grp);
          grant.group_count = rwcgs_pkg::COUNT_BITS'(grp + 1);
          grant.overflow = ovf;
        end
        grant_q.push_back(grant);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_grant(rwcgs_pkg::rsp_t got);
    rwcgs_pkg::rsp_t want;
    if (grant_q.size() == 0) begin
      $error("result word with none pending: group %0d, group_count %0d, overflow %0d",
             got.group, got.group_count, got.overflow);
      fail_n++;
    end else begin
      want = grant_q.pop_front();
      checked_n++;
      if (got.group !== want.group) begin
        $error("group: expected %0d, got %0d", want.group, got.group);
        fail_n++;
      end
      if (got.group_count !== want.group_count) begin
        $error("group_count: expected %0d, got %0d", want.group_count, got.group_count);
        fail_n++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        fail_n++;
      end
    end
  endfunction

  function automatic void push_word(logic [1:0] code, logic [rwcgs_pkg::ID_BITS-1:0] id,
                                    logic wr, logic bar, logic ups);
    rwcgs_pkg::req_t w;
    w.op = rwcgs_pkg::op_t'(code);
    w.rel_id = id;
    w.rel_is_write = wr;
    w.barrier = bar;
    w.upsert = ups;
    pending_words.push_back(w);
    if (code != OP_UNUSED) queued_n++;
  endfunction

  function automatic void push_rel(logic [rwcgs_pkg::ID_BITS-1:0] id, logic wr);
    push_word(rwcgs_pkg::OP_REL, id, wr, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic void push_close(logic bar, logic ups);
    push_word(rwcgs_pkg::OP_CLOSE, $urandom(), 1'($urandom_range(1)), bar, ups);
  endfunction

  function automatic void queue_batch(int entries, int rels_lo, int rels_hi, int spread);
    logic [rwcgs_pkg::ID_BITS-1:0] base;
    logic [rwcgs_pkg::ID_BITS-1:0] id;
    base = $urandom();
    batches_n++;
    push_word(rwcgs_pkg::OP_CLEAR, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    for (int e = 0; e < entries; e++) begin
      for (int r = $urandom_range(rels_hi, rels_lo); r > 0; r--) begin
        id = ($urandom_range(9) == 0) ? $urandom() : base + $urandom_range(spread);
        push_rel(id, 1'($urandom_range(1)));
      end
      push_close($urandom_range(9) == 0, 1'($urandom_range(1)));
    end
  endfunction

  function automatic void queue_segment(bit with_overruns);
    int unsigned start_n;
    int unsigned pick;
    start_n = queued_n;
    if (with_overruns) begin
      queue_batch(ENTRY_CAP + 4, 0, 1, 7);
      queue_batch(3, 44, 48, 15);
    end
    while (queued_n - start_n < SEGMENT_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        queue_batch(ENTRY_CAP + $urandom_range(4, 1), 0, 1, 7);
      end else if (pick < 8) begin
        queue_batch(3, 44, 48, 15);
      end else if (pick < 80) begin
        queue_batch($urandom_range(12, 1), 0, 3, 3);
      end else if (pick < 90) begin
        // entry left open, then the batch restarts
        push_word(rwcgs_pkg::OP_CLEAR, $urandom(), 1'b0, 1'b1, 1'b0);
        repeat ($urandom_range(5, 1)) push_rel($urandom_range(3), 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(3, 1))
          push_word(OP_UNUSED, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        push_rel($urandom(), 1'($urandom_range(1)));
        push_close(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (pending_words.size() != 0 || req_valid || grant_q.size() != 0);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [rwcgs_pkg::COUNT_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    per_group = value;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        assign_group(req);
        accepted_n++;
      end
      if (!req_valid || req_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          req <= pending_words.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) check_grant(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_n, grant_q.size());
      $display("** read_write_conflict_group_scheduler: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [rwcgs_pkg::COUNT_BITS-1:0] limit;
    per_group = rwcgs_pkg::MAX_PER_GROUP_RESET;
    clear_batch();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle = 30;
    recv_idle = 55;

    // directed words under the reset limit
    push_close(1'b0, 1'b1);
    push_word(rwcgs_pkg::OP_CLEAR, '0, 1'b0, 1'b0, 1'b0);
    push_rel(32'h0000_0000, 1'b0);
    push_rel(32'hFFFF_FFFF, 1'b1);
    push_close(1'b0, 1'b0);
    push_rel(32'h0000_0000, 1'b0);
    push_close(1'b0, 1'b1);
    push_rel(32'hFFFF_FFFF, 1'b0);
    push_close(1'b0, 1'b0);
    push_rel(32'h0000_0000, 1'b1);
    push_close(1'b0, 1'b0);
    push_word(OP_UNUSED, '1, 1'b1, 1'b1, 1'b1);
    push_close(1'b1, 1'b0);
    push_close(1'b0, 1'b1);
    push_rel(32'h5555_AAAA, 1'b1);
    push_rel(32'h5555_AAAA, 1'b1);
    push_close(1'b0, 1'b0);
    push_word(rwcgs_pkg::OP_CLEAR, '1, 1'b1, 1'b1, 1'b1);
    push_close(1'b1, 1'b1);
    push_rel(32'hAAAA_5555, 1'b0);
    push_close(1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: limit = 7'd1;
        1: limit = 7'd64;
        2: limit = 7'd0;
        3: limit = 7'd127;
        4: limit = 7'd3;
        default: limit = 7'd2;
      endcase
      wait_drained();
      write_limit(limit);
      @(negedge clk);
      send_idle = (p < 2) ? 30 : (p < 4) ? 55 : 0;
      recv_idle = (p < 2) ? 55 : (p < 4) ? 30 : 0;
      queue_segment(p == 0);
    end
    wait_drained();

    $display("covered %0d request words in %0d batches over %0d limit settings",
             accepted_n, batches_n, PHASES + 1);
    $display("%0d group results checked, %0d mismatches", checked_n, fail_n);
    if (fail_n == 0) begin
      $display("** read_write_conflict_group_scheduler: PASSED **");
    end else begin
      $display("** read_write_conflict_group_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rwcgs_pkg.sv
design/read_write_conflict_group_scheduler.sv
dv/tb.sv
